@@ src/pfwts_pkg.sv @@
// ----------------------------------------------------------------------------
// pfwts_pkg
// Shared types, codes and constants of the per-flow window statistics block.
// ----------------------------------------------------------------------------
package pfwts_pkg;

  // Default number of flow slots.
  localparam int FLOWS_DEF = 16;

  // Request kinds carried in tuser.
  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_TX    = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;
  localparam logic [1:0] REQ_CLOSE = 2'd3;

  // Statistic being computed during a close run.
  typedef logic [2:0] op_t;
  localparam op_t OP_RATE = 3'd0;
  localparam op_t OP_GAP  = 3'd1;
  localparam op_t OP_GCV  = 3'd2;
  localparam op_t OP_SIZE = 3'd3;
  localparam op_t OP_SCV  = 3'd4;
  localparam op_t OP_LAT  = 3'd5;
  localparam int  NUM_OPS = 6;

  // Fixed-point and field constants.
  localparam logic [31:0] WINDOW_RST = 32'd199999000;
  localparam logic [15:0] RATE_MULT  = 16'd8000;
  localparam logic [40:0] Q_ONE      = 41'd65536;
  localparam logic [39:0] MAX40      = 40'hFF_FFFF_FFFF;

  // Widths of the shared arithmetic units.
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 48;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 104;
  localparam int DIV_DW = 96;
  localparam int DIV_QW = 41;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic prep;
    logic commit;
    logic use_scan;
    logic mul_start;
    logic mul_second;
    logic save_p0;
    logic save_p1;
    logic div_start;
    logic save_res;
    logic emit;
    op_t  op;
  } pfwts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] item_req;
    logic       active;
    logic       rx_nz;
    logic       out_free;
    logic       mul_busy;
    logic       mul_done;
    logic       div_busy;
    logic       div_done;
  } pfwts_status_t;

  // Statistics that need products before the division.
  function automatic logic needs_mul(op_t op);
    return (op == OP_RATE) || (op == OP_GCV) || (op == OP_SCV);
  endfunction

  // Statistics that are CV^2 values.
  function automatic logic is_cv(op_t op);
    return (op == OP_GCV) || (op == OP_SCV);
  endfunction

endpackage

@@ src/per_flow_window_traffic_stats.sv @@
// ----------------------------------------------------------------------------
// per_flow_window_traffic_stats
// Per-flow windowed traffic statistics with one-pass mean and CV^2.
// ----------------------------------------------------------------------------
// Items arrive on the in_ stream: tuser carries the request kind (open,
// transmit, receive, close window), tdata the flow slot, time, packet size
// and latency. Open, transmit and receive words update the flow table in
// order: accept, prepare the gap and squares, commit.
// A close word walks every slot, passing inactive slots one slot a cycle,
// and for each active slot produces one out_ word with tlast on the final
// slot of the run. Each active slot needs a product for the rate, two per
// CV^2, and a division per statistic in the one shared divider; latency is
// divided only when the window saw receives. The user writes window_ns on
// the cfg_ channel while the block is idle; the block does not enforce it.
// Reset empties the flow table, clears all sums and held values, and sets
// window_ns to 199999000. Results wait in an output register; while the
// receiver stalls the walk holds at the next finished slot and no input
// word is taken until the run ends.
// ----------------------------------------------------------------------------
module per_flow_window_traffic_stats
  import pfwts_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // flow[3:0], time_ns[51:4], packet_size[67:52], latency_ns[99:68]
  input  logic [103:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_flow[3:0], mean_rate_q16[43:4], mean_gap_q16[83:44],
  // gap_cv_sqr_q16[123:84], mean_size_q16[163:124], size_cv_sqr_q16[203:164],
  // tx_count[227:204], tx_byte_total[267:228], rx_count[291:268],
  // rx_byte_total[331:292], mean_latency_q16[371:332]
  output logic [375:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  pfwts_cmd_t    cmd;
  pfwts_status_t status;
  logic [IW-1:0] scan_idx;

  assign cfg_ready = 1'b1;

  pfwts_ctrl #(.FLOWS(FLOWS), .IW(IW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  pfwts_datapath #(.FLOWS(FLOWS), .IW(IW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .scan_idx   (scan_idx),
    .status     (status),
    .in_req     (in_tuser),
    .in_word    (in_tdata),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ src/pfwts_mul.sv @@
// ----------------------------------------------------------------------------
// pfwts_mul
// Multi-cycle multiplier, 64 x 48 bits, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module pfwts_mul
  import pfwts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic              busy,
  output logic              done,
  output logic [MUL_PW-1:0] prod
);

  localparam int DIG   = 16;
  localparam int STEPS = MUL_BW / DIG;

  logic [MUL_AW-1:0]    a_r;
  logic [MUL_BW-1:0]    b_r;
  logic [MUL_PW-1:0]    acc_r;
  logic [1:0]           cnt_r;
  logic                 busy_r, done_r;
  logic [MUL_AW+DIG-1:0] pp;

  // Partial product of the top remaining digit.
  assign pp = {{DIG{1'b0}}, a_r} * {{MUL_AW{1'b0}}, b_r[MUL_BW-1 -: DIG]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= {acc_r[MUL_PW-DIG-1:0], {DIG{1'b0}}} + MUL_PW'(pp);
        b_r   <= {b_r[MUL_BW-DIG-1:0], {DIG{1'b0}}};
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ src/pfwts_div.sv @@
// ----------------------------------------------------------------------------
// pfwts_div
// Restoring divider, one quotient bit per cycle, quotient capped at 41 bits.
// ----------------------------------------------------------------------------
module pfwts_div
  import pfwts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] n,
  input  logic [DIV_DW-1:0] d,
  output logic              busy,
  output logic              done,
  output logic [DIV_QW-1:0] q
);

  localparam int SW = DIV_DW + DIV_QW - 1;

  logic [DIV_NW-1:0] rem_r;
  logic [SW-1:0]     dsh_r;
  logic [DIV_QW-1:0] q_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic              ovf;
  logic              fits;

  // Quotient would need more than 41 bits.
  assign ovf  = {{(SW+1-DIV_NW){1'b0}}, n} >= {d, {DIV_QW{1'b0}}};
  assign fits = {{(SW-DIV_NW){1'b0}}, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= n;
        dsh_r <= {d, {(DIV_QW-1){1'b0}}};
        cnt_r <= '0;
        if (d == '0) begin
          q_r    <= '0;
          done_r <= 1'b1;
        end else if (ovf) begin
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r[DIV_NW-1:0];
        end
        q_r   <= {q_r[DIV_QW-2:0], fits};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q    = q_r;

endmodule

@@ src/pfwts_datapath.sv @@
// ----------------------------------------------------------------------------
// pfwts_datapath
// Flow table, update arithmetic, shared multiplier and divider, result
// registers and the output word register.
// ----------------------------------------------------------------------------
module pfwts_datapath
  import pfwts_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF,
  parameter int IW    = (FLOWS > 1) ? $clog2(FLOWS) : 1
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  pfwts_cmd_t    cmd,
  input  logic [IW-1:0] scan_idx,
  output pfwts_status_t status,
  input  logic [1:0]    in_req,
  input  logic [103:0]  in_word,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [375:0]  out_tdata,
  output logic          out_tlast
);

  // Configuration and captured item.
  logic [31:0] window_r;
  logic [1:0]  req_r;
  logic [3:0]  flow_r;
  logic [47:0] time_r;
  logic [15:0] pkt_r;
  logic [31:0] lat_r;

  // Flow table.
  logic [FLOWS-1:0] active_r;
  logic [FLOWS-1:0] have_prev_r;
  logic [47:0] prev_time_r [FLOWS];
  logic [23:0] tx_n_r      [FLOWS];
  logic [39:0] tx_b_r      [FLOWS];
  logic [63:0] tx_sq_r     [FLOWS];
  logic [47:0] gap_sum_r   [FLOWS];
  logic [63:0] gap_sq_r    [FLOWS];
  logic [23:0] rx_n_r      [FLOWS];
  logic [39:0] rx_b_r      [FLOWS];
  logic [55:0] lat_sum_r   [FLOWS];
  logic [23:0] h_cnt_r     [FLOWS];
  logic [39:0] h_bytes_r   [FLOWS];
  logic [39:0] h_lat_r     [FLOWS];

  // Update pipeline registers.
  logic [47:0] gap_r;
  logic [63:0] gsq_r;
  logic [33:0] szsq_r;

  // Close run registers.
  logic [87:0] p0_r;
  logic [95:0] p1_r;
  logic [39:0] res_r [NUM_OPS];

  // Output word register.
  logic        out_valid_r;
  logic [3:0]  o_flow_r;
  logic [39:0] o_rate_r, o_gap_r, o_gcv_r, o_size_r, o_scv_r, o_txb_r, o_rxb_r, o_lat_r;
  logic [23:0] o_txc_r, o_rxc_r;
  logic        o_last_r;

  logic [IW-1:0] rd;
  logic          flow_ok;
  logic [16:0]   sz;
  logic [47:0]   gap;
  logic [23:0]   gaps;
  logic          more_after;

  // Read address is the scan slot in a close run, else the item's slot.
  assign rd      = cmd.use_scan ? scan_idx : IW'(flow_r);
  assign flow_ok = (32'(flow_r) < FLOWS);
  assign sz      = {1'b0, pkt_r} + 17'd2;
  assign gap     = (time_r >= prev_time_r[rd]) ? (time_r - prev_time_r[rd]) : 48'd0;
  assign gaps    = (tx_n_r[rd] != 24'd0) ? (tx_n_r[rd] - 24'd1) : 24'd0;

  // Saturating sums for the commit step.
  logic [24:0] s_txn, s_rxn;
  logic [40:0] s_txb, s_rxb;
  logic [64:0] s_txsq, s_gsq;
  logic [48:0] s_gsum;
  logic [56:0] s_lat;
  assign s_txn  = {1'b0, tx_n_r[rd]} + 25'd1;
  assign s_rxn  = {1'b0, rx_n_r[rd]} + 25'd1;
  assign s_txb  = {1'b0, tx_b_r[rd]} + 41'(sz);
  assign s_rxb  = {1'b0, rx_b_r[rd]} + 41'(sz);
  assign s_txsq = {1'b0, tx_sq_r[rd]} + 65'(szsq_r);
  assign s_gsq  = {1'b0, gap_sq_r[rd]} + {1'b0, gsq_r};
  assign s_gsum = {1'b0, gap_sum_r[rd]} + {1'b0, gap_r};
  assign s_lat  = {1'b0, lat_sum_r[rd]} + 57'(lat_r);

  // Multiplier operand selection.
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RATE: begin
        mul_a = 64'(tx_b_r[rd]);
        mul_b = 48'(RATE_MULT);
      end
      OP_GCV: begin
        mul_a = cmd.mul_second ? 64'(gap_sum_r[rd]) : gap_sq_r[rd];
        mul_b = cmd.mul_second ? gap_sum_r[rd] : 48'(gaps);
      end
      OP_SCV: begin
        mul_a = cmd.mul_second ? 64'(tx_b_r[rd]) : tx_sq_r[rd];
        mul_b = cmd.mul_second ? 48'(tx_b_r[rd]) : 48'(tx_n_r[rd]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operand selection.
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  always_comb begin
    div_n = '0;
    div_d = '0;
    case (cmd.op)
      OP_RATE: begin
        div_n = {p0_r, 16'd0};
        div_d = 96'(window_r);
      end
      OP_GAP: begin
        div_n = {40'd0, gap_sum_r[rd], 16'd0};
        div_d = 96'(gaps);
      end
      OP_GCV, OP_SCV: begin
        div_n = {p0_r, 16'd0};
        div_d = p1_r;
      end
      OP_SIZE: begin
        div_n = {48'd0, tx_b_r[rd], 16'd0};
        div_d = 96'(tx_n_r[rd]);
      end
      OP_LAT: begin
        div_n = {32'd0, lat_sum_r[rd], 16'd0};
        div_d = 96'(rx_n_r[rd]);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  logic [MUL_PW-1:0] prod;
  logic              mul_busy, mul_done;
  logic [DIV_QW-1:0] quo;
  logic              div_busy, div_done;

  pfwts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  pfwts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .n     (div_n),
    .d     (div_d),
    .busy  (div_busy),
    .done  (div_done),
    .q     (quo)
  );

  // Quotient to statistic: saturate, and take 1 off for CV^2 values.
  logic [40:0] cv_q;
  logic [39:0] res_val;
  assign cv_q = quo - Q_ONE;
  always_comb begin
    if (is_cv(cmd.op)) begin
      if (quo <= Q_ONE) begin
        res_val = '0;
      end else begin
        res_val = cv_q[40] ? MAX40 : cv_q[39:0];
      end
    end else begin
      res_val = quo[40] ? MAX40 : quo[39:0];
    end
  end

  // Another active slot after the current one closes the run otherwise.
  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < FLOWS; j++) begin
      if ((IW'(j) > scan_idx) && active_r[j]) begin
        more_after = 1'b1;
      end
    end
  end

  logic        rx_nz;
  logic [23:0] new_hcnt;
  logic [39:0] new_hbytes, new_hlat;
  assign rx_nz      = (rx_n_r[rd] != 24'd0);
  assign new_hcnt   = rx_nz ? rx_n_r[rd] : h_cnt_r[rd];
  assign new_hbytes = rx_nz ? rx_b_r[rd] : h_bytes_r[rd];
  assign new_hlat   = rx_nz ? res_r[OP_LAT] : h_lat_r[rd];

  // Item capture, configuration and close run registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      window_r <= cfg_data;
    end
    if (cmd.load_item) begin
      req_r  <= in_req;
      flow_r <= in_word[3:0];
      time_r <= in_word[51:4];
      pkt_r  <= in_word[67:52];
      lat_r  <= in_word[99:68];
    end
    if (cmd.prep) begin
      gap_r  <= gap;
      gsq_r  <= (gap[47:32] != 16'd0) ? '1 : (64'(gap[31:0]) * 64'(gap[31:0]));
      szsq_r <= 34'(sz) * 34'(sz);
    end
    if (cmd.save_p0) begin
      p0_r <= prod[87:0];
    end
    if (cmd.save_p1) begin
      p1_r <= prod[95:0];
    end
    if (cmd.save_res) begin
      res_r[cmd.op] <= res_val;
    end
  end

  // Flow table updates: item commit and close-run clearing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      have_prev_r <= '0;
      for (int i = 0; i < FLOWS; i++) begin
        prev_time_r[i] <= '0;
        tx_n_r[i]      <= '0;
        tx_b_r[i]      <= '0;
        tx_sq_r[i]     <= '0;
        gap_sum_r[i]   <= '0;
        gap_sq_r[i]    <= '0;
        rx_n_r[i]      <= '0;
        rx_b_r[i]      <= '0;
        lat_sum_r[i]   <= '0;
        h_cnt_r[i]     <= '0;
        h_bytes_r[i]   <= '0;
        h_lat_r[i]     <= '0;
      end
    end else if (cmd.commit && flow_ok) begin
      case (req_r)
        REQ_OPEN: begin
          active_r[rd] <= 1'b1;
        end
        REQ_TX: begin
          if (active_r[rd]) begin
            tx_n_r[rd]  <= s_txn[24] ? '1 : s_txn[23:0];
            tx_b_r[rd]  <= s_txb[40] ? '1 : s_txb[39:0];
            tx_sq_r[rd] <= s_txsq[64] ? '1 : s_txsq[63:0];
            if (have_prev_r[rd]) begin
              gap_sum_r[rd] <= s_gsum[48] ? '1 : s_gsum[47:0];
              gap_sq_r[rd]  <= s_gsq[64] ? '1 : s_gsq[63:0];
            end
            prev_time_r[rd] <= time_r;
            have_prev_r[rd] <= 1'b1;
          end
        end
        REQ_RX: begin
          if (active_r[rd]) begin
            rx_n_r[rd]    <= s_rxn[24] ? '1 : s_rxn[23:0];
            rx_b_r[rd]    <= s_rxb[40] ? '1 : s_rxb[39:0];
            lat_sum_r[rd] <= s_lat[56] ? '1 : s_lat[55:0];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.emit) begin
      h_cnt_r[rd]     <= new_hcnt;
      h_bytes_r[rd]   <= new_hbytes;
      h_lat_r[rd]     <= new_hlat;
      have_prev_r[rd] <= 1'b0;
      tx_n_r[rd]      <= '0;
      tx_b_r[rd]      <= '0;
      tx_sq_r[rd]     <= '0;
      gap_sum_r[rd]   <= '0;
      gap_sq_r[rd]    <= '0;
      rx_n_r[rd]      <= '0;
      rx_b_r[rd]      <= '0;
      lat_sum_r[rd]   <= '0;
    end
  end

  // Output word register: loaded on emit, freed when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      o_flow_r <= 4'(rd);
      o_rate_r <= res_r[OP_RATE];
      o_gap_r  <= res_r[OP_GAP];
      o_gcv_r  <= res_r[OP_GCV];
      o_size_r <= res_r[OP_SIZE];
      o_scv_r  <= res_r[OP_SCV];
      o_txc_r  <= tx_n_r[rd];
      o_txb_r  <= tx_b_r[rd];
      o_rxc_r  <= new_hcnt;
      o_rxb_r  <= new_hbytes;
      o_lat_r  <= new_hlat;
      o_last_r <= !more_after;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'd0, o_lat_r, o_rxb_r, o_rxc_r, o_txb_r, o_txc_r,
                       o_scv_r, o_size_r, o_gcv_r, o_gap_r, o_rate_r, o_flow_r};

  assign status.item_req = req_r;
  assign status.active   = active_r[rd];
  assign status.rx_nz    = rx_nz;
  assign status.out_free = !out_valid_r || out_tready;
  assign status.mul_busy = mul_busy;
  assign status.mul_done = mul_done;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

endmodule

@@ src/pfwts_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfwts_ctrl
// Controller: item handshake, update sequence and the close-run sequencer
// that walks the flow slots and steps through the statistics.
// ----------------------------------------------------------------------------
module pfwts_ctrl
  import pfwts_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF,
  parameter int IW    = (FLOWS > 1) ? $clog2(FLOWS) : 1
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfwts_status_t status,
  output pfwts_cmd_t    cmd,
  output logic [IW-1:0] scan_idx
);

  localparam int SW = $clog2(FLOWS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPD1  = 4'd1;
  localparam logic [3:0] S_UPD2  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MUL0  = 4'd4;
  localparam logic [3:0] S_MUL0W = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL1W = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  op_t           op_r, op_nxt;
  logic          idx_end;

  assign idx_end  = (idx_r == SW'(FLOWS));
  assign scan_idx = idx_r[IW-1:0];
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.use_scan = (state_r != S_IDLE) && (state_r != S_UPD1) && (state_r != S_UPD2);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_UPD1;
        end
      end
      S_UPD1: begin
        if (status.item_req == REQ_CLOSE) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = S_UPD2;
        end
      end
      S_UPD2: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      // Walk to the next active slot, one slot a cycle.
      S_SCAN: begin
        if (idx_end) begin
          state_nxt = S_IDLE;
        end else if (status.active) begin
          op_nxt    = OP_RATE;
          state_nxt = S_MUL0;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_MUL0: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL0W;
      end
      S_MUL0W: begin
        if (status.mul_done) begin
          cmd.save_p0 = 1'b1;
          state_nxt   = is_cv(op_r) ? S_MUL1 : S_DIV;
        end
      end
      S_MUL1: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_second = 1'b1;
        state_nxt      = S_MUL1W;
      end
      S_MUL1W: begin
        if (status.mul_done) begin
          cmd.save_p1 = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      // Store the statistic and pick the next one.
      S_DIVW: begin
        if (status.div_done) begin
          cmd.save_res = 1'b1;
          if (op_r == OP_LAT) begin
            state_nxt = S_EMIT;
          end else if (op_r == OP_SCV) begin
            if (status.rx_nz) begin
              op_nxt    = OP_LAT;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_EMIT;
            end
          end else begin
            op_nxt    = op_r + op_t'(1);
            state_nxt = needs_mul(op_r + op_t'(1)) ? S_MUL0 : S_DIV;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      op_r    <= OP_RATE;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      op_r    <= op_nxt;
    end
  end

  // An emitted word never overwrites one the receiver has not taken.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free) else $error("emit into a full output register");

  // The shared units are never restarted while busy.
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !status.mul_busy) else $error("multiplier restarted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.div_busy) else $error("divider restarted while busy");

  // A started division is always followed by the wait for its quotient.
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_DIVW)) else $error("division left unattended");

endmodule
